>>> rtl/rmsn_pkg.sv
`timescale 1ns / 1ps
package rmsn_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CNT_W = 13;
  localparam int CFG_W = 13;
  localparam int MAX_ROW = 4096;
  localparam int ROW_RESET = 768;
  localparam int DEF_QUEUE_DEPTH = 2;
  localparam int SUM_W = 48;
  localparam int INV_W = 32;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 49;
  localparam int SQRT_IN_W = 64;
  localparam int SQRT_OUT_W = 32;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_ROW_LENGTH = 1'b1;
  localparam logic MODE_BWD = 1'b1;

  typedef enum logic {
    KIND_ACC  = 1'b0,
    KIND_NORM = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e                     kind;
    logic signed [SAMPLE_BITS-1:0]  x;
    logic signed [SAMPLE_BITS-1:0]  g;
  } item_t;

  typedef struct packed {
    logic             mode;
    logic [CFG_W-1:0] row_length;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [INV_W-1:0] inv_rms;
  } back_stat_t;

endpackage

>>> rtl/rmsn_in_if.sv
`timescale 1ns / 1ps
interface rmsn_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] x_value;
  logic signed [15:0] grad_value;

  modport source (output valid, output opcode, output x_value, output grad_value,
                  input ready);
  modport sink (input valid, input opcode, input x_value, input grad_value,
                output ready);
endinterface

>>> rtl/rmsn_out_if.sv
`timescale 1ns / 1ps
interface rmsn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] y_value;
  logic               row_last;

  modport source (output valid, output y_value, output row_last, input ready);
  modport sink (input valid, input y_value, input row_last, output ready);
endinterface

>>> rtl/rmsn_front.sv
`timescale 1ns / 1ps
module rmsn_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  rmsn_in_if.sink        in_chan,
  output logic           fr_valid_o,
  output rmsn_pkg::item_t fr_item_o,
  input  logic           q_ready_i
);
  import rmsn_pkg::*;

  logic  valid_d, valid_q;
  item_t item_d, item_q;

  assign in_chan.ready = !valid_q || q_ready_i;

  always_comb begin
    valid_d = valid_q;
    item_d = item_q;
    if (valid_q && q_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_chan.valid && in_chan.ready) begin
      valid_d = 1'b1;
      item_d.kind = in_chan.opcode ? KIND_NORM : KIND_ACC;
      item_d.x = in_chan.x_value;
      item_d.g = in_chan.grad_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign fr_valid_o = valid_q;
  assign fr_item_o = item_q;
endmodule

>>> rtl/rmsn_queue.sv
`timescale 1ns / 1ps
module rmsn_queue #(
  parameter int DEPTH = rmsn_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  rmsn_pkg::item_t          item_i,
  output logic                     ready_o,
  output logic                     valid_o,
  output rmsn_pkg::item_t          item_o,
  input  logic                     pop_i,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);
  import rmsn_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_d, wr_q, rd_d, rd_q;
  logic [LVL_W-1:0]  lvl_d, lvl_q;
  logic              do_push, do_pop;

  assign ready_o = lvl_q != LVL_W'(DEPTH);
  assign valid_o = lvl_q != '0;
  assign item_o = mem_q[rd_q];
  assign level_o = lvl_q;
  assign do_push = push_i && ready_o;
  assign do_pop = pop_i && valid_o;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    lvl_d = lvl_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + LVL_W'(1);
    end else if (!do_push && do_pop) begin
      lvl_d = lvl_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      lvl_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end
endmodule

>>> rtl/rmsn_div.sv
`timescale 1ns / 1ps
module rmsn_div #(
  parameter int N_W = rmsn_pkg::DIV_N_W,
  parameter int D_W = rmsn_pkg::DIV_D_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quotient_o
);
  localparam int C_W = $clog2(N_W);
  localparam logic [C_W-1:0] C_LAST = C_W'(N_W - 1);

  logic           busy_d, busy_q, done_d, done_q;
  logic [C_W-1:0] cnt_d, cnt_q;
  logic [D_W-1:0] rem_d, rem_q, dsr_d, dsr_q;
  logic [N_W-1:0] quo_d, quo_q;
  logic [D_W:0]   shifted, diff;

  assign shifted = {rem_q, quo_q[N_W-1]};
  assign diff = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    quo_d = quo_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      dsr_d = divisor_i;
      quo_d = dividend_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = diff[D_W-1:0];
        quo_d = {quo_q[N_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[D_W-1:0];
        quo_d = {quo_q[N_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + C_W'(1);
      if (cnt_q == C_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;
endmodule

>>> rtl/rmsn_sqrt.sv
`timescale 1ns / 1ps
module rmsn_sqrt #(
  parameter int IN_W = rmsn_pkg::SQRT_IN_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IN_W-1:0]   radicand_i,
  output logic              done_o,
  output logic [IN_W/2-1:0] root_o
);
  localparam int R_W = IN_W / 2;
  localparam int C_W = $clog2(R_W);
  localparam logic [C_W-1:0] C_LAST = C_W'(R_W - 1);

  logic            busy_d, busy_q, done_d, done_q;
  logic [C_W-1:0]  cnt_d, cnt_q;
  logic [R_W+1:0]  rem_d, rem_q;
  logic [R_W-1:0]  root_d, root_q;
  logic [IN_W-1:0] rad_d, rad_q;
  logic [R_W+3:0]  shifted, trial, diff;

  assign shifted = {rem_q, rad_q[IN_W-1:IN_W-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign diff = shifted - trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    root_d = root_q;
    rad_d = rad_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      root_d = '0;
      rad_d = radicand_i;
    end else if (busy_q) begin
      rad_d = {rad_q[IN_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d = diff[R_W+1:0];
        root_d = {root_q[R_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[R_W+1:0];
        root_d = {root_q[R_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + C_W'(1);
      if (cnt_q == C_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    root_q <= root_d;
    rad_q <= rad_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

>>> rtl/rmsn_back.sv
`timescale 1ns / 1ps
module rmsn_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rmsn_pkg::cfg_t       cfg_i,
  input  logic                 q_valid_i,
  input  rmsn_pkg::item_t      q_item_i,
  output logic                 q_pop_o,
  rmsn_out_if.source           out_chan,
  output rmsn_pkg::back_stat_t stat_o
);
  import rmsn_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_ACC     = 11'b000_0000_0010,
    S_DIV_M   = 11'b000_0000_0100,
    S_DIV_R   = 11'b000_0000_1000,
    S_SQRT    = 11'b000_0001_0000,
    S_DIV_T   = 11'b000_0010_0000,
    S_MUL_LO  = 11'b000_0100_0000,
    S_MUL_HI  = 11'b000_1000_0000,
    S_MUL_SUM = 11'b001_0000_0000,
    S_NORM2   = 11'b010_0000_0000,
    S_NORM3   = 11'b100_0000_0000
  } state_e;

  localparam logic [SUM_W-1:0] SQ_CAP = '1;
  localparam logic signed [SUM_W:0] GX_MAX = (49'sd1 <<< (SUM_W - 1)) - 49'sd1;
  localparam logic signed [SUM_W:0] GX_MIN = -(49'sd1 <<< (SUM_W - 1));
  localparam logic [62:0] MUL_CAP = 63'd1 << 62;
  localparam logic [62:0] T_CAP = (63'd1 << (SUM_W - 1)) - 63'd1;
  localparam logic signed [65:0] Y_MAX = (66'sd1 <<< (SAMPLE_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] Y_MIN = -(66'sd1 <<< (SAMPLE_BITS - 1));
  localparam logic signed [65:0] RND_FWD = 66'sd1 <<< 19;
  localparam logic signed [65:0] RND_BWD = 66'sd1 <<< 29;
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_ROW);

  state_e                  state_d, state_q;
  logic [CNT_W-1:0]        count_d, count_q, n_d, n_q, eff_n;
  logic [CNT_W:0]          count_inc;
  logic                    at_end;
  logic [SUM_W-1:0]        sum_sq_d, sum_sq_q, a_d, a_q;
  logic signed [SUM_W-1:0] sum_gx_d, sum_gx_q, gs_d, gs_q;
  logic [INV_W-1:0]        inv_d, inv_q;
  logic signed [31:0]      prod_sq_d, prod_sq_q, prod_gx_d, prod_gx_q;
  logic                    mode_d, mode_q, neg_d, neg_q;
  logic signed [15:0]      x_d, x_q;
  logic signed [48:0]      pn1_d, pn1_q;
  logic signed [63:0]      pn2_d, pn2_q;
  logic [62:0]             work_d, work_q, mul_sat;
  logic [1:0]              k_d, k_q;
  logic [63:0]             plo_d, plo_q;
  logic [62:0]             phi_d, phi_q;
  logic [74:0]             mul_sum;
  logic [SUM_W:0]          sq_sum;
  logic signed [SUM_W:0]   gx_sum, gx_next_w;
  logic [SUM_W-1:0]        sq_next;
  logic signed [SUM_W-1:0] gx_next;
  logic [SUM_W:0]          gx_neg;
  logic [46:0]             t_final;
  logic signed [65:0]      acc, rnd, ysh, ysat;
  logic                    out_valid_d, out_valid_q, out_last_d, out_last_q;
  logic signed [15:0]      out_y_d, out_y_q;
  logic                    div_start, div_done, sq_start, sq_done;
  logic [DIV_N_W-1:0]      div_dividend, div_quo;
  logic [DIV_D_W-1:0]      div_divisor;
  logic [SQRT_IN_W-1:0]    sq_radicand;
  logic [SQRT_OUT_W-1:0]   sq_root;

  rmsn_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dividend), .divisor_i(div_divisor),
    .done_o(div_done), .quotient_o(div_quo)
  );

  rmsn_sqrt #(.IN_W(SQRT_IN_W)) u_sqrt (
    .clk_i, .rst_ni,
    .start_i(sq_start), .radicand_i(sq_radicand),
    .done_o(sq_done), .root_o(sq_root)
  );

  always_comb begin
    if (cfg_i.row_length == '0) begin
      eff_n = CNT_W'(1);
    end else if (cfg_i.row_length > N_MAX) begin
      eff_n = N_MAX;
    end else begin
      eff_n = cfg_i.row_length;
    end
  end

  assign count_inc = {1'b0, count_q} + (CNT_W+1)'(1);
  assign at_end = count_inc >= {1'b0, eff_n};

  assign sq_sum = {1'b0, sum_sq_q} + (SUM_W+1)'(prod_sq_q[30:0]);
  assign sq_next = sq_sum[SUM_W] ? SQ_CAP : sq_sum[SUM_W-1:0];
  assign gx_sum = {sum_gx_q[SUM_W-1], sum_gx_q}
                  + {{(SUM_W-31){prod_gx_q[31]}}, prod_gx_q};
  always_comb begin
    if (mode_q != MODE_BWD) begin
      gx_next_w = {sum_gx_q[SUM_W-1], sum_gx_q};
    end else if (gx_sum > GX_MAX) begin
      gx_next_w = GX_MAX;
    end else if (gx_sum < GX_MIN) begin
      gx_next_w = GX_MIN;
    end else begin
      gx_next_w = gx_sum;
    end
  end
  assign gx_next = gx_next_w[SUM_W-1:0];
  assign gx_neg = -gx_next_w;

  assign mul_sum = {phi_q, 12'b0} + 75'(plo_q[63:20]);
  assign mul_sat = (mul_sum > 75'(MUL_CAP)) ? MUL_CAP : mul_sum[62:0];
  assign t_final = (mul_sat > T_CAP) ? T_CAP[46:0] : mul_sat[46:0];

  always_comb begin
    if (mode_q != MODE_BWD) begin
      acc = 66'(pn1_q);
      rnd = acc + RND_FWD;
      ysh = rnd >>> 20;
    end else begin
      acc = (66'(pn1_q) <<< 10) - 66'(pn2_q);
      rnd = acc + RND_BWD;
      ysh = rnd >>> 30;
    end
    if (ysh > Y_MAX) begin
      ysat = Y_MAX;
    end else if (ysh < Y_MIN) begin
      ysat = Y_MIN;
    end else begin
      ysat = ysh;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d = n_q;
    sum_sq_d = sum_sq_q;
    sum_gx_d = sum_gx_q;
    a_d = a_q;
    neg_d = neg_q;
    inv_d = inv_q;
    gs_d = gs_q;
    prod_sq_d = prod_sq_q;
    prod_gx_d = prod_gx_q;
    mode_d = mode_q;
    x_d = x_q;
    pn1_d = pn1_q;
    pn2_d = pn2_q;
    work_d = work_q;
    k_d = k_q;
    plo_d = plo_q;
    phi_d = phi_q;
    out_valid_d = out_valid_q && !out_chan.ready;
    out_y_d = out_y_q;
    out_last_d = out_last_q;
    q_pop_o = 1'b0;
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor = '0;
    sq_start = 1'b0;
    sq_radicand = div_quo;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          x_d = q_item_i.x;
          mode_d = cfg_i.mode;
          if (q_item_i.kind == KIND_ACC) begin
            prod_sq_d = q_item_i.x * q_item_i.x;
            prod_gx_d = q_item_i.g * q_item_i.x;
            state_d = S_ACC;
          end else begin
            pn1_d = ((cfg_i.mode == MODE_BWD) ? q_item_i.g : q_item_i.x)
                    * $signed({17'b0, inv_q});
            state_d = S_NORM2;
          end
        end
      end
      S_ACC: begin
        if (at_end) begin
          n_d = eff_n;
          neg_d = gx_next < 0;
          a_d = gx_next[SUM_W-1] ? gx_neg[SUM_W-1:0] : gx_next;
          sum_sq_d = '0;
          sum_gx_d = '0;
          count_d = '0;
          div_start = 1'b1;
          div_dividend = DIV_N_W'(sq_next);
          div_divisor = DIV_D_W'(eff_n);
          state_d = S_DIV_M;
        end else begin
          sum_sq_d = sq_next;
          sum_gx_d = gx_next;
          count_d = count_inc[CNT_W-1:0];
          state_d = S_IDLE;
        end
      end
      S_DIV_M: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dividend = DIV_N_W'(1) << 60;
          div_divisor = div_quo[DIV_D_W-1:0] + DIV_D_W'(1);
          state_d = S_DIV_R;
        end
      end
      S_DIV_R: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          inv_d = sq_root;
          div_start = 1'b1;
          div_dividend = {6'b0, a_q, 10'b0};
          div_divisor = DIV_D_W'(n_q);
          state_d = S_DIV_T;
        end
      end
      S_DIV_T: begin
        if (div_done) begin
          work_d = div_quo[62:0];
          k_d = '0;
          state_d = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        plo_d = work_q[31:0] * inv_q;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        phi_d = work_q[62:32] * inv_q;
        state_d = S_MUL_SUM;
      end
      S_MUL_SUM: begin
        work_d = mul_sat;
        if (k_q == 2'd2) begin
          gs_d = neg_q ? -$signed({1'b0, t_final}) : $signed({1'b0, t_final});
          state_d = S_IDLE;
        end else begin
          k_d = k_q + 2'd1;
          state_d = S_MUL_LO;
        end
      end
      S_NORM2: begin
        pn2_d = x_q * gs_q;
        state_d = S_NORM3;
      end
      S_NORM3: begin
        if (!out_valid_q || out_chan.ready) begin
          out_valid_d = 1'b1;
          out_y_d = ysat[15:0];
          out_last_d = at_end;
          count_d = at_end ? '0 : count_inc[CNT_W-1:0];
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      sum_sq_q <= '0;
      sum_gx_q <= '0;
      inv_q <= '0;
      gs_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_sq_q <= sum_sq_d;
      sum_gx_q <= sum_gx_d;
      inv_q <= inv_d;
      gs_q <= gs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    a_q <= a_d;
    neg_q <= neg_d;
    prod_sq_q <= prod_sq_d;
    prod_gx_q <= prod_gx_d;
    mode_q <= mode_d;
    x_q <= x_d;
    pn1_q <= pn1_d;
    pn2_q <= pn2_d;
    work_q <= work_d;
    k_q <= k_d;
    plo_q <= plo_d;
    phi_q <= phi_d;
    out_y_q <= out_y_d;
    out_last_q <= out_last_d;
  end

  assign out_chan.valid = out_valid_q;
  assign out_chan.y_value = out_y_q;
  assign out_chan.row_last = out_last_q;
  assign stat_o.count = count_q;
  assign stat_o.inv_rms = inv_q;
endmodule

>>> rtl/rms_normalization_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                          Handshake
// in_chan   in         opcode, x_value, grad_value      valid / ready
// out_chan  out        y_value, row_last                valid / ready
// cfg       in         cfg_index_i, cfg_data_i          cfg_we_i
//
// Accumulate elements run S_IDLE, S_ACC; normalize elements S_IDLE, S_NORM2, S_NORM3.
// The element that closes an accumulate pass then runs three 64-step divisions
// on the shared divider, a 32-step square root and three two-part multiplies.
// The front register and queue keep taking transactions while the back end works, until full.
// Reset is asynchronous and active low; no clearing pass is needed.
module rms_normalization_top #(
  parameter int QUEUE_DEPTH = rmsn_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rmsn_in_if.sink                    in_chan,
  rmsn_out_if.source                 out_chan,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [rmsn_pkg::CFG_W-1:0] cfg_data_i
);
  import rmsn_pkg::*;

  cfg_t                          cfg_d, cfg_q;
  logic                          fr_valid, q_ready, q_valid, q_pop;
  item_t                         fr_item, q_item;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;
  back_stat_t                    stat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE: cfg_d.mode = cfg_data_i[0];
        CFG_ROW_LENGTH: cfg_d.row_length = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= 1'b0;
      cfg_q.row_length <= CFG_W'(ROW_RESET);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rmsn_front u_front (
    .clk_i, .rst_ni, .in_chan,
    .fr_valid_o(fr_valid), .fr_item_o(fr_item), .q_ready_i(q_ready)
  );

  rmsn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i(fr_valid), .item_i(fr_item), .ready_o(q_ready),
    .valid_o(q_valid), .item_o(q_item), .pop_i(q_pop), .level_o(q_level)
  );

  rmsn_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_chan, .stat_o(stat)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count < CNT_W'(MAX_ROW))
    else $error("element counter passed the row length limit");

  a_inv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.inv_rms <= (INV_W'(1) << 30))
    else $error("inverse rms out of range");

  a_queue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue level above depth");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");
`endif
endmodule
